FILE: rtl/wgm_pkg.sv
// shared types and constants for the wildcard glob matcher
`default_nettype none
package wgm_pkg;

   // widest pattern the register file can hold
   localparam int MAX_BYTES = 16;

   // special pattern and text characters
   localparam logic [7:0] CH_STAR = 8'h2A;
   localparam logic [7:0] CH_ANY  = 8'h3F;
   localparam logic [7:0] CH_DOT  = 8'h2E;

   // configuration register indexes
   typedef enum logic [1:0] {
      REG_PATTERN_LOW    = 2'd0,
      REG_PATTERN_HIGH   = 2'd1,
      REG_PATTERN_LENGTH = 2'd2
   } csr_index_type;

   // pattern bytes, byte 0 in the lowest bits
   typedef logic [MAX_BYTES-1:0][7:0] pattern_type;

   // configuration as seen by the position logic
   typedef struct packed {
      pattern_type pattern;
      logic [4:0]  length;
   } cfg_type;

   // one text byte handed to the position logic
   typedef struct packed {
      logic       fire;
      logic       last;
      logic [7:0] text;
   } step_type;

endpackage
`default_nettype wire

FILE: rtl/wgm_csr.sv
// configuration registers of the wildcard glob matcher
`default_nettype none
module wgm_csr
   import wgm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   output cfg_type     cfg
);

   logic [63:0] pattern_low_ff, pattern_low_in;
   logic [63:0] pattern_high_ff, pattern_high_in;
   logic [4:0]  pattern_length_ff, pattern_length_in;

   // register write decode
   always_comb begin
      pattern_low_in    = pattern_low_ff;
      pattern_high_in   = pattern_high_ff;
      pattern_length_in = pattern_length_ff;
      if (csr_write) begin
         case (csr_index)
            REG_PATTERN_LOW:    pattern_low_in    = csr_wdata;
            REG_PATTERN_HIGH:   pattern_high_in   = csr_wdata;
            REG_PATTERN_LENGTH: pattern_length_in = csr_wdata[4:0];
            default:            pattern_low_in    = pattern_low_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_length_ff <= '0;
      end else begin
         pattern_low_ff    <= pattern_low_in;
         pattern_high_ff   <= pattern_high_in;
         pattern_length_ff <= pattern_length_in;
      end
   end

   // byte 0 lands in the lowest bits
   assign cfg.pattern = {pattern_high_ff, pattern_low_ff};
   assign cfg.length  = pattern_length_ff;

endmodule
`default_nettype wire

FILE: rtl/wgm_nfa.sv
// live pattern position set and its per-byte update
`default_nettype none
module wgm_nfa
   import wgm_pkg::*;
#(
   parameter int PATTERN_BYTES = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  step_type step,
   output logic     matched
);

   localparam int         W   = PATTERN_BYTES;
   localparam logic [4:0] CAP = 5'(W);

   logic [W:0]   live_ff, live_in;
   logic [4:0]   used;
   logic [W:0]   keep;
   logic [W:0]   at_end;
   logic [W-1:0] star;
   logic [W-1:0] hit;
   logic [W:0]   cur;
   logic [W:0]   adv;
   logic [W:0]   next;
   logic [W:0]   restart;

   // a live star position also makes the position after it live
   function automatic logic [W:0] close_stars(input logic [W:0] s, input logic [W-1:0] st);
      logic [W:0] r;
      r = s;
      for (int p = 0; p < W; p++) begin
         if (r[p] && st[p]) r[p+1] = 1'b1;
      end
      return r;
   endfunction

   // position decode and one step of the automaton
   always_comb begin
      used = (cfg.length > CAP) ? CAP : cfg.length;
      for (int k = 0; k <= W; k++) begin
         keep[k]   = (5'(k) <= used);
         at_end[k] = (5'(k) == used);
      end
      for (int p = 0; p < W; p++) begin
         star[p] = (5'(p) < used) && (cfg.pattern[p] == CH_STAR);
         hit[p]  = (5'(p) < used) && (cfg.pattern[p] != CH_STAR) &&
                   ((cfg.pattern[p] == step.text) ||
                    ((cfg.pattern[p] == CH_ANY) && (step.text != CH_DOT)));
      end
      cur = close_stars(live_ff & keep, star);
      adv = '0;
      for (int p = 0; p < W; p++) begin
         if (cur[p] && star[p]) adv[p] = 1'b1;
         if (cur[p] && hit[p])  adv[p+1] = 1'b1;
      end
      next    = close_stars(adv, star);
      restart = close_stars((W+1)'(1), star);
      matched = |(next & at_end);
      live_in = live_ff;
      if (step.fire) begin
         live_in = step.last ? restart : next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= (W+1)'(1);
      end else begin
         live_ff <= live_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/wildcard_glob_matcher_unit.sv
// Glob matcher: one text byte per request, one result per text on its last byte.
// The pattern (up to PATTERN_BYTES bytes, '*' any run, '?' any byte but '.') is
// set through the csr port while no text is in flight. A request is taken every
// cycle while the input register holds no waiting byte; each byte passes an
// input register, one pass of the position update logic and, for a last byte,
// the result register, from which the result is valid. Only a last byte meeting
// a held result waits in the input register, which throttles the request side.
`default_nettype none
module wildcard_glob_matcher_unit
   import wgm_pkg::*;
#(
   parameter int PATTERN_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_matched,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   cfg_type    cfg;
   step_type   step;
   logic       matched;
   logic       req_fire;
   logic       rsp_free;
   logic       s1_go;
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_text_ff;
   logic       s1_last_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_matched_ff;

   wgm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wgm_nfa #(
      .PATTERN_BYTES (PATTERN_BYTES)
   ) u_nfa (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step    (step),
      .matched (matched)
   );

   // handshake: only a last byte needs room in the result register
   always_comb begin
      rsp_free    = !rsp_valid_ff || !rsp_stall;
      s1_go       = s1_valid_ff && (!s1_last_ff || rsp_free);
      req_stall   = s1_valid_ff && !s1_go;
      req_fire    = req_valid && !req_stall;
      s1_valid_in = req_fire || (s1_valid_ff && !s1_go);
      step.fire   = s1_go;
      step.last   = s1_last_ff;
      step.text   = s1_text_ff;
      if (s1_go && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_text_ff <= req_text_byte;
         s1_last_ff <= req_last_byte;
      end
      if (s1_go && s1_last_ff) begin
         rsp_matched_ff <= matched;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_matched = rsp_matched_ff;

`ifndef SYNTHESIS
   // a last byte never overwrites a result still held
   a_last_waits: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_last_ff && rsp_valid_ff && rsp_stall |-> req_stall)
      else $error("last byte advanced over a held result");

   // every last byte that leaves the input register yields a result
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_last_ff |=> rsp_valid_ff)
      else $error("result missing after last byte");

   // a new result only comes from a last byte
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_go && s1_last_ff))
      else $error("result without a last byte");
`endif

endmodule
`default_nettype wire

FILE: dv/wildcard_glob_matcher_unit_test.sv
// self-checking testbench for the wildcard glob matcher unit
`timescale 1ns / 1ps
module wildcard_glob_matcher_unit_test;
   import wgm_pkg::*;

   localparam int PATTERN_BYTES = 16;

   // tracks expected match flags with its own copy of the pattern and live positions
   class glob_match_board;
      logic [63:0] pattern_low;
      logic [63:0] pattern_high;
      logic [4:0]  pattern_length;
      logic [16:0] live_set;
      logic        expected_matches[$];
      int          mismatches;

      function new();
         pattern_low    = '0;
         pattern_high   = '0;
         pattern_length = '0;
         mismatches     = 0;
         live_set       = close_stars(17'd1, 0);
      endfunction

      function void set_reg(csr_index_type idx, logic [63:0] data);
         case (idx)
            REG_PATTERN_LOW:    pattern_low = data;
            REG_PATTERN_HIGH:   pattern_high = data;
            REG_PATTERN_LENGTH: pattern_length = data[4:0];
            default: ;
         endcase
      endfunction

      // length in use, clipped to the pattern storage
      function int used_length();
         int n;
         n = pattern_length;
         if (n > PATTERN_BYTES) n = PATTERN_BYTES;
         if (n > MAX_BYTES) n = MAX_BYTES;
         return n;
      endfunction

      function logic [7:0] pattern_char(int p);
         if (p < 8) return pattern_low[p*8 +: 8];
         return pattern_high[(p-8)*8 +: 8];
      endfunction

      // drop positions past n, then let every live star also enable the next position
      function logic [16:0] close_stars(logic [16:0] positions, int n);
         for (int p = 0; p <= 16; p++)
            if (p > n) positions[p] = 1'b0;
         for (int p = 0; p < n; p++)
            if (positions[p] && pattern_char(p) == CH_STAR) positions[p+1] = 1'b1;
         return positions;
      endfunction

      // advance the live positions by one accepted text byte
      function void take_byte(logic [7:0] text, logic last);
         int          n;
         logic [16:0] cur;
         logic [16:0] nxt;
         logic [7:0]  pc;
         n   = used_length();
         cur = close_stars(live_set, n);
         nxt = '0;
         for (int p = 0; p < n; p++) begin
            if (cur[p]) begin
               pc = pattern_char(p);
               if (pc == CH_STAR) nxt[p] = 1'b1;
               else if (pc == text || (pc == CH_ANY && text != CH_DOT)) nxt[p+1] = 1'b1;
            end
         end
         nxt = close_stars(nxt, n);
         if (last) begin
            expected_matches.push_back(nxt[n]);
            live_set = close_stars(17'd1, n);
         end else begin
            live_set = nxt;
         end
      endfunction

      function void log_error(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
      endfunction

      function void check_match(logic got);
         logic want;
         if (expected_matches.size() == 0) begin
            log_error($sformatf("result with no text pending: matched %0b", got));
         end else begin
            want = expected_matches.pop_front();
            if (got !== want) log_error($sformatf("matched expected %0b got %0b", want, got));
         end
      endfunction

      function int pending();
         return expected_matches.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_text_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_matched;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [63:0] csr_wdata;

   glob_match_board board = new();
   int          bytes_sent = 0;
   bit          no_idle = 1'b0;
   bit          long_hold_pending = 1'b0;

   wildcard_glob_matcher_unit #(.PATTERN_BYTES(PATTERN_BYTES)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_text_byte(req_text_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_matched(rsp_matched),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // monitor both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.take_byte(req_text_byte, req_last_byte);
         if (rsp_valid && !rsp_stall) board.check_match(rsp_matched);
      end
   end

   // receiver stall pattern, with one long hold on request
   initial begin
      int run;
      int r;
      bit stalling;
      rsp_stall = 1'b0;
      forever begin
         r = $urandom_range(0, 99);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            stalling = 1'b1;
            run = 200;
         end else if (no_idle || r < 60) begin
            stalling = 1'b0;
            run = $urandom_range(1, 6);
         end else if (r < 90) begin
            stalling = 1'b1;
            run = $urandom_range(1, 3);
         end else if (r < 97) begin
            stalling = 1'b1;
            run = $urandom_range(4, 12);
         end else begin
            stalling = 1'b1;
            run = $urandom_range(20, 60);
         end
         repeat (run) begin
            @(negedge clock);
            rsp_stall <= stalling;
         end
      end
   end

   // run limit
   initial begin
      #(64'd16_000_000);
      $display("end of test: mismatches");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // offer one request and hold it until taken; entered and left just after a falling edge
   task automatic send_request(input logic [7:0] text, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= text;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(ref logic [7:0] text[$]);
      for (int i = 0; i < text.size(); i++) send_request(text[i], i == text.size() - 1);
   endtask

   task automatic send_word(input string s);
      logic [7:0] text[$];
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
      send_text(text);
   endtask

   // wait for every pending match flag, then let the pipeline settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [63:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      board.set_reg(idx, data);
      @(negedge clock);
   endtask

   task automatic configure(input logic [127:0] pattern, input logic [4:0] length);
      write_reg(REG_PATTERN_LOW, pattern[63:0]);
      write_reg(REG_PATTERN_HIGH, pattern[127:64]);
      write_reg(REG_PATTERN_LENGTH, {59'd0, length});
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [127:0] pattern_of(input string s);
      logic [127:0] bits;
      bits = '0;
      for (int i = 0; i < s.len() && i < 16; i++) bits[i*8 +: 8] = s[i];
      return bits;
   endfunction

   function automatic logic [7:0] random_pattern_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) return CH_STAR;
      if (r < 45) return CH_ANY;
      if (r < 53) return CH_DOT;
      if (r < 85) return 8'h61 + 8'($urandom_range(0, 2));
      if (r < 95) return 8'($urandom_range(0, 255));
      return 8'h00;
   endfunction

   function automatic logic [7:0] random_text_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 8'h61 + 8'($urandom_range(0, 2));
      if (r < 75) return CH_DOT;
      return 8'($urandom_range(1, 255));
   endfunction

   // mostly texts shaped after the pattern, some mutated, some plain noise
   task automatic make_text(input logic [127:0] pattern, input int n, ref logic [7:0] text[$]);
      int         r;
      logic [7:0] pc;
      text.delete();
      r = $urandom_range(0, 99);
      if (r < 20) begin
         repeat ($urandom_range(1, 10)) text.push_back(random_text_char());
      end else begin
         for (int p = 0; p < n; p++) begin
            pc = pattern[p*8 +: 8];
            if (pc == CH_STAR) repeat ($urandom_range(0, 3)) text.push_back(random_text_char());
            else if (pc == CH_ANY || pc == 8'h00) text.push_back(random_text_char());
            else text.push_back(pc);
         end
         if (r < 40 && text.size() > 0) text[$urandom_range(0, text.size() - 1)] = random_text_char();
         else if (r < 46 && text.size() > 0) void'(text.pop_back());
         else if (r < 52) text.push_back(random_text_char());
      end
      if (text.size() == 0) text.push_back(random_text_char());
      while (text.size() > 24) void'(text.pop_back());
   endtask

   // stimulus
   initial begin
      logic [127:0] pattern;
      logic [4:0]   length;
      logic [7:0]   text[$];
      int           phase;
      int           r;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_text_byte = 8'h00;
      req_last_byte = 1'b0;
      csr_write     = 1'b0;
      csr_index     = REG_PATTERN_LOW;
      csr_wdata     = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty pattern after reset never matches
      send_word("x");
      wait_idle();

      // lone star matches anything
      configure(pattern_of("*"), 5'd1);
      text = '{8'hFF};
      send_text(text);
      send_word("ab");
      wait_idle();

      // question mark takes any byte but a dot
      configure(pattern_of("a?c"), 5'd3);
      send_word("abc");
      send_word("a.c");
      wait_idle();

      // a run of stars acts as one
      configure(pattern_of("**x"), 5'd3);
      send_word("x");
      send_word("yx");
      send_word("xy");
      wait_idle();

      // oversized length clips to the full pattern
      configure(pattern_of("????????********"), 5'd31);
      text = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80};
      send_text(text);
      wait_idle();

      // random phases, each with its own pattern
      phase = 0;
      while (bytes_sent < 1470) begin
         for (int i = 0; i < 16; i++) pattern[i*8 +: 8] = random_pattern_char();
         r = $urandom_range(0, 99);
         if (r < 10) length = 5'd0;
         else if (r < 20) length = 5'd16;
         else if (r < 28) length = 5'($urandom_range(17, 31));
         else length = 5'($urandom_range(1, 10));
         case (phase)
            0: begin
               pattern = '1;
               length  = 5'd16;
            end
            1: begin
               pattern = '0;
               length  = 5'd0;
            end
            2: length = 5'd31;
            default: ;
         endcase
         configure(pattern, length);
         no_idle = (phase > 3 && $urandom_range(0, 4) == 0);
         if (phase == 4) long_hold_pending = 1'b1;
         repeat (phase == 4 ? 40 : $urandom_range(3, 10)) begin
            make_text(pattern, board.used_length(), text);
            send_text(text);
         end
         wait_idle();
         phase++;
      end

      no_idle = 1'b0;
      wait_idle();
      repeat (10) @(negedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
